// ===== rtl/osm_pkg.sv =====
// Shared types and codes for the order-statistic multiset.
// Used by osm_cell and order_statistic_multiset; no other dependencies.
package osm_pkg;

    localparam int ActionBits = 5;
    localparam int FieldBits  = 32;
    localparam int KBits      = 6;
    localparam int NumBits    = 8;
    localparam int OccBits    = 7;

    localparam logic [ActionBits-1:0] ACT_INSERT   = 5'd0;
    localparam logic [ActionBits-1:0] ACT_DISCARD  = 5'd1;
    localparam logic [ActionBits-1:0] ACT_POP_MIN  = 5'd2;
    localparam logic [ActionBits-1:0] ACT_POP_MAX  = 5'd3;
    localparam logic [ActionBits-1:0] ACT_MIN      = 5'd4;
    localparam logic [ActionBits-1:0] ACT_MAX      = 5'd5;
    localparam logic [ActionBits-1:0] ACT_FLOOR    = 5'd6;
    localparam logic [ActionBits-1:0] ACT_LOWER    = 5'd7;
    localparam logic [ActionBits-1:0] ACT_CEILING  = 5'd8;
    localparam logic [ActionBits-1:0] ACT_HIGHER   = 5'd9;
    localparam logic [ActionBits-1:0] ACT_KTH_MIN  = 5'd10;
    localparam logic [ActionBits-1:0] ACT_KTH_MAX  = 5'd11;
    localparam logic [ActionBits-1:0] ACT_CONTAINS = 5'd12;
    localparam logic [ActionBits-1:0] ACT_COUNT    = 5'd13;
    localparam logic [ActionBits-1:0] ACT_RANK_TOP = 5'd14;
    localparam logic [ActionBits-1:0] ACT_RANK_TPL = 5'd15;
    localparam logic [ActionBits-1:0] ACT_RANK_BOT = 5'd16;
    localparam logic [ActionBits-1:0] ACT_RANK_BTR = 5'd17;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [ActionBits-1:0]      action;
        logic signed [FieldBits-1:0] value;
        logic [KBits-1:0]           rank_index;
    } osm_in_t;

    typedef struct packed {
        logic signed [FieldBits-1:0] result_value;
        logic signed [NumBits-1:0]   result_number;
        logic [1:0]                  status;
        logic [OccBits-1:0]          occupancy_out;
    } osm_out_t;

    // Per-cycle control broadcast to every cell of the chain.
    typedef struct packed {
        logic sample;   // latch compare flags against the new operand
        logic ins;      // open a slot at the insert point and shift right
        logic del;      // close the slot at the first cell not below x
        logic pop;      // shift the whole chain one place toward cell 0
    } osm_ctl_t;

endpackage

// ===== rtl/osm_cell.sv =====
// One cell of the sorted chain: holds a value and its compare flags.
// Depends on osm_pkg for the control struct.
module osm_cell
    import osm_pkg::*;
#(
    parameter int VALUE_BITS = 32
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  osm_ctl_t                     ctl,
    input  logic                         valid_in,
    input  logic signed [VALUE_BITS-1:0] x_in,
    input  logic signed [VALUE_BITS-1:0] x_hold,
    input  logic signed [VALUE_BITS-1:0] left_val,
    input  logic                         left_le,
    input  logic signed [VALUE_BITS-1:0] right_val,
    output logic signed [VALUE_BITS-1:0] val,
    output logic                         lt,
    output logic                         le
);

    logic signed [VALUE_BITS-1:0] val_reg;
    logic                         lt_reg;
    logic                         le_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lt_reg <= 1'b0;
            le_reg <= 1'b0;
        end else if (ctl.sample) begin
            lt_reg <= valid_in && (val_reg < x_in);
            le_reg <= valid_in && (val_reg <= x_in);
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.ins && !le_reg) begin
            val_reg <= left_le ? x_hold : left_val;
        end else if ((ctl.del && !lt_reg) || ctl.pop) begin
            val_reg <= right_val;
        end
    end

    assign val = val_reg;
    assign lt  = lt_reg;
    assign le  = le_reg;

endmodule

// ===== rtl/order_statistic_multiset.sv =====
// Order-statistic multiset: a sorted chain of CAPACITY cells.
// A new input is accepted only while idle, so items never overlap.
// Accepting an input latches every cell's compare against x; the execute state reduces
// the flags, shifts the chain and registers the result. A stalled result holds that state.
// Reset (aresetn, synchronous, active low) empties the store at once;
// cell contents are not cleared since only cells below occupancy are read.
module order_statistic_multiset
    import osm_pkg::*;
#(
    parameter int CAPACITY   = 64,
    parameter int VALUE_BITS = 32
) (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  osm_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output osm_out_t m_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int NW = CW + 2;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                         state_reg;
    logic [CW-1:0]                occ_reg;
    logic [ActionBits-1:0]        act_reg;
    logic [KBits-1:0]             k_reg;
    logic signed [VALUE_BITS-1:0] x_reg;
    logic                         m_valid_reg;
    osm_out_t                     m_data_reg;

    logic signed [VALUE_BITS-1:0] x_in;
    logic signed [VALUE_BITS-1:0] cell_val [CAPACITY];
    logic [CAPACITY-1:0]          cell_lt;
    logic [CAPACITY-1:0]          cell_le;
    logic                         accept;
    logic                         commit;
    osm_ctl_t                     ctl;

    assign x_in    = VALUE_BITS'(s_data.value);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;
    // The result register is free when empty or being drained this cycle.
    assign commit  = (state_reg == ST_EXEC) && (!m_valid_reg || m_ready);

    // Counts below x (lo) and at or below x (le_cnt). The flags form
    // thermometer codes over the sorted chain, so each count is found
    // from the single boundary cell where the code drops.
    logic [CAPACITY-1:0] lt_edge, le_edge, lt_first, le_first;
    logic [CW-1:0]       lo, le_cnt, occ_m1;
    logic [CW:0]         eq_w;
    logic                has_eq, non_empty, k_ok;

    assign lt_edge  = cell_lt & ~{1'b0, cell_lt[CAPACITY-1:1]};
    assign le_edge  = cell_le & ~{1'b0, cell_le[CAPACITY-1:1]};
    assign lt_first = ~cell_lt & {cell_lt[CAPACITY-2:0], 1'b1};
    assign le_first = ~cell_le & {cell_le[CAPACITY-2:0], 1'b1};

    always_comb begin
        lo     = '0;
        le_cnt = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (lt_edge[i]) lo     = lo     | CW'(i + 1);
            if (le_edge[i]) le_cnt = le_cnt | CW'(i + 1);
        end
    end

    assign eq_w      = {1'b0, le_cnt} - {1'b0, lo};
    assign has_eq    = (le_cnt != lo);
    assign non_empty = (occ_reg != '0);
    assign occ_m1    = occ_reg - CW'(1);
    assign k_ok      = ((CW + KBits)'(k_reg) < (CW + KBits)'(occ_reg));

    // Pick the one cell that an action reads, then reduce with an OR.
    logic [CAPACITY-1:0]          sel;
    logic                         found;
    logic signed [VALUE_BITS-1:0] picked;

    always_comb begin
        sel   = '0;
        found = 1'b0;
        case (act_reg) inside
            ACT_POP_MIN, ACT_MIN: begin
                sel[0] = 1'b1;
                found  = non_empty;
            end
            ACT_POP_MAX, ACT_MAX: begin
                for (int i = 0; i < CAPACITY; i++) sel[i] = (CW'(i) == occ_m1);
                found = non_empty;
            end
            ACT_FLOOR: begin
                sel   = le_edge;
                found = (le_cnt != '0);
            end
            ACT_LOWER: begin
                sel   = lt_edge;
                found = (lo != '0);
            end
            ACT_CEILING: begin
                sel   = lt_first;
                found = (lo < occ_reg);
            end
            ACT_HIGHER: begin
                sel   = le_first;
                found = (le_cnt < occ_reg);
            end
            ACT_KTH_MIN: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    sel[i] = ((CW + KBits)'(i) == (CW + KBits)'(k_reg));
                end
                found = k_ok;
            end
            ACT_KTH_MAX: begin
                for (int i = 0; i < CAPACITY; i++) begin
                    sel[i] = ((CW + KBits)'(i) + (CW + KBits)'(k_reg)
                              == (CW + KBits)'(occ_m1));
                end
                found = k_ok;
            end
            default: begin
                sel   = '0;
                found = 1'b0;
            end
        endcase
    end

    always_comb begin
        picked = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (sel[i]) picked = picked | cell_val[i];
        end
    end

    // Rank and count results, all in a signed width that holds -1..CAPACITY.
    logic signed [NW-1:0] s_n, lo_n, le_n, eq_n, num;
    logic [1:0]           status;
    logic                 is_lookup;
    logic [CW-1:0]        occ_next;
    logic                 do_ins, do_del, do_pop_min, do_pop_max;

    assign s_n  = NW'(occ_reg);
    assign lo_n = NW'(lo);
    assign le_n = NW'(le_cnt);
    assign eq_n = NW'(eq_w);

    assign do_ins     = (act_reg == ACT_INSERT) && (occ_reg < CW'(CAPACITY));
    assign do_del     = (act_reg == ACT_DISCARD) && has_eq;
    assign do_pop_min = (act_reg == ACT_POP_MIN) && non_empty;
    assign do_pop_max = (act_reg == ACT_POP_MAX) && non_empty;
    assign is_lookup  = (act_reg >= ACT_POP_MIN) && (act_reg <= ACT_KTH_MAX);

    always_comb begin
        num    = '0;
        status = STATUS_OK;
        case (act_reg)
            ACT_INSERT:   if (!do_ins) status = STATUS_FULL;
            ACT_DISCARD:  if (!has_eq) status = STATUS_NOT_FOUND;
            ACT_CONTAINS: num = has_eq ? NW'(1) : NW'(0);
            ACT_COUNT:    num = eq_n;
            ACT_RANK_TOP: num = has_eq ? (s_n - le_n) : (s_n - lo_n - NW'(1));
            ACT_RANK_TPL: num = s_n - lo_n - NW'(1);
            ACT_RANK_BOT: num = lo_n;
            ACT_RANK_BTR: num = has_eq ? (le_n - NW'(1)) : lo_n;
            default: begin
                if (!is_lookup || !found) status = STATUS_NOT_FOUND;
            end
        endcase
    end

    always_comb begin
        occ_next = occ_reg;
        if (do_ins) begin
            occ_next = occ_reg + CW'(1);
        end else if (do_del || do_pop_min || do_pop_max) begin
            occ_next = occ_m1;
        end
    end

    assign ctl.sample = accept;
    assign ctl.ins    = commit && do_ins;
    assign ctl.del    = commit && do_del;
    assign ctl.pop    = commit && do_pop_min;

    // The chain: each cell sees its neighbors' values and the left flag.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VALUE_BITS-1:0] left_val;
        logic signed [VALUE_BITS-1:0] right_val;
        logic                         left_le;
        if (g == 0) begin : g_first
            assign left_val = x_reg;
            assign left_le  = 1'b1;
        end else begin : g_mid
            assign left_val = cell_val[g-1];
            assign left_le  = cell_le[g-1];
        end
        if (g == CAPACITY - 1) begin : g_last
            assign right_val = cell_val[g];
        end else begin : g_inner
            assign right_val = cell_val[g+1];
        end
        osm_cell #(
            .VALUE_BITS(VALUE_BITS)
        ) u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .ctl      (ctl),
            .valid_in (CW'(g) < occ_reg),
            .x_in     (x_in),
            .x_hold   (x_reg),
            .left_val (left_val),
            .left_le  (left_le),
            .right_val(right_val),
            .val      (cell_val[g]),
            .lt       (cell_lt[g]),
            .le       (cell_le[g])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            occ_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    if (m_ready) m_valid_reg <= 1'b0;
                    if (accept) state_reg <= ST_EXEC;
                end
                ST_EXEC: begin
                    if (commit) begin
                        m_valid_reg <= 1'b1;
                        occ_reg     <= occ_next;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            act_reg <= s_data.action;
            k_reg   <= s_data.rank_index;
            x_reg   <= x_in;
        end
        if (commit) begin
            // Found values leave as the raw stored pattern, zero-extended.
            m_data_reg.result_value  <= (is_lookup && found)
                                        ? FieldBits'(unsigned'(picked)) : '0;
            m_data_reg.result_number <= NumBits'(num);
            m_data_reg.status        <= status;
            m_data_reg.occupancy_out <= OccBits'(occ_next);
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
